// ===== src/assert_macros.svh =====
// Assertion macros shared by the link supervisor modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define LSRT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");
// Check that a condition never holds outside reset.
`define LSRT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("forbidden condition seen");
`else
`define LSRT_ASSERT(lbl, clk, rst_n, prop)
`define LSRT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== src/lsrt_pkg.sv =====
// Types and constants shared by the link supervisor modules.
package lsrt_pkg;

  typedef enum logic [2:0] {
    OP_BEGIN     = 3'd0,
    OP_SERVICE   = 3'd1,
    OP_SESS_UP   = 3'd2,
    OP_SESS_DOWN = 3'd3,
    OP_MSG_IN    = 3'd4,
    OP_START     = 3'd5,
    OP_POLL      = 3'd6,
    OP_CLOSE     = 3'd7
  } opcode_e;

  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_FAILED    = 3'd1,
    ST_IDLE      = 3'd2,
    ST_PENDING   = 3'd3,
    ST_COMPLETED = 3'd4,
    ST_TIMEOUT   = 3'd5
  } poll_status_e;

  // Configuration register indexes
  localparam logic [2:0] CFG_RESP_TIMEOUT  = 3'd0;
  localparam logic [2:0] CFG_RADIO_TIMEOUT = 3'd1;
  localparam logic [2:0] CFG_RADIO_RETRY   = 3'd2;
  localparam logic [2:0] CFG_SESS_TIMEOUT  = 3'd3;
  localparam logic [2:0] CFG_SESS_RETRY    = 3'd4;

  // Configuration reset values in milliseconds
  localparam logic [31:0] RESP_TIMEOUT_RST  = 32'd5000;
  localparam logic [31:0] RADIO_TIMEOUT_RST = 32'd15000;
  localparam logic [31:0] RADIO_RETRY_RST   = 32'd3000;
  localparam logic [31:0] SESS_TIMEOUT_RST  = 32'd5000;
  localparam logic [31:0] SESS_RETRY_RST    = 32'd3000;

  // Requests from the item decoder to the reconnect logic
  typedef struct packed {
    logic run;       // apply the reconnect rule
    logic clear;     // wipe attempt stamps and pending flags first
    logic sess_set;  // session came up
    logic sess_clr;  // session went down or failed
  } lsrt_sup_ctl_t;

  // Commands issued by the reconnect rule
  typedef struct packed {
    logic radio_begin;
    logic radio_drop;
    logic session_begin;
    logic session_drop;
  } lsrt_cmd_t;

  // Reconnect timing configuration
  typedef struct packed {
    logic [31:0] radio_timeout;
    logic [31:0] radio_retry;
    logic [31:0] sess_timeout;
    logic [31:0] sess_retry;
  } lsrt_timing_t;

endpackage

// ===== src/link_supervisor_with_request_timeout.sv =====
// Top level: item decode, request tracking, configuration and result register.
// The block takes one item per clock cycle unless in_stall_o is high and presents its
// result from an output register in the cycle after acceptance; in_stall_o rises
// only while that register holds a result that the receiver stalls. All supervision
// state is updated in the accepting cycle; the response handle of a completed poll is
// read from the message ring memory at the accepting edge and appears with the
// result. The ring memory needs no clearing pass after reset.
`include "assert_macros.svh"
module link_supervisor_with_request_timeout #(
  parameter int RING_DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [31:0] now_ms_i,
  input  logic        radio_up_i,
  input  logic [31:0] message_word_i,
  input  logic [31:0] payload_word_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        radio_begin_o,
  output logic        radio_drop_o,
  output logic        session_begin_o,
  output logic        session_drop_o,
  output logic        send_now_o,
  output logic [31:0] send_word_o,
  output logic        request_accepted_o,
  output logic [2:0]  poll_status_o,
  output logic [31:0] response_word_o,
  output logic        link_up_o
);
  import lsrt_pkg::*;

  // Configuration registers
  logic [31:0]   resp_to_q;
  lsrt_timing_t  timing_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resp_to_q              <= RESP_TIMEOUT_RST;
      timing_q.radio_timeout <= RADIO_TIMEOUT_RST;
      timing_q.radio_retry   <= RADIO_RETRY_RST;
      timing_q.sess_timeout  <= SESS_TIMEOUT_RST;
      timing_q.sess_retry    <= SESS_RETRY_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RESP_TIMEOUT:  resp_to_q              <= cfg_wdata_i;
        CFG_RADIO_TIMEOUT: timing_q.radio_timeout <= cfg_wdata_i;
        CFG_RADIO_RETRY:   timing_q.radio_retry   <= cfg_wdata_i;
        CFG_SESS_TIMEOUT:  timing_q.sess_timeout  <= cfg_wdata_i;
        CFG_SESS_RETRY:    timing_q.sess_retry    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake
  logic out_valid_q;
  logic fire;
  assign in_stall_o = out_valid_q && out_stall_i;
  assign fire       = in_valid_i && !in_stall_o;

  // Request and start state
  logic        started_q, started_d;
  logic        act_q, act_d;
  logic [31:0] req_start_q, req_start_d;

  // Decode reconnect requests
  lsrt_sup_ctl_t ctl;
  always_comb begin
    ctl = '0;
    case (opcode_i)
      OP_BEGIN: begin
        ctl.run   = 1'b1;
        ctl.clear = 1'b1;
      end
      OP_SERVICE, OP_START, OP_POLL: ctl.run = started_q;
      OP_SESS_UP:   ctl.sess_set = 1'b1;
      OP_SESS_DOWN: ctl.sess_clr = 1'b1;
      default: ;
    endcase
    if (!fire) begin
      ctl = '0;
    end
  end

  lsrt_cmd_t cmd;
  logic      conn_d;
  logic      link_d;

  lsrt_supervisor u_sup (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .timing_i   (timing_q),
    .now_ms_i   (now_ms_i),
    .radio_up_i (radio_up_i),
    .cmd_o      (cmd),
    .conn_d_o   (conn_d)
  );

  assign link_d = radio_up_i && conn_d;

  // Ring access
  logic        push, pop, clr, nonempty;
  logic [31:0] ring_rdata;

  lsrt_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .pop_i      (pop),
    .clr_i      (clr),
    .wdata_i    (message_word_i),
    .nonempty_o (nonempty),
    .rdata_o    (ring_rdata)
  );

  // Request tracking and result fields
  poll_status_e status;
  logic         accepted;
  logic         resp_timed_out;

  assign resp_timed_out = (now_ms_i - req_start_q) >= resp_to_q;

  always_comb begin
    started_d   = started_q;
    act_d       = act_q;
    req_start_d = req_start_q;
    status      = ST_NONE;
    accepted    = 1'b0;
    push        = 1'b0;
    pop         = 1'b0;
    clr         = 1'b0;
    case (opcode_i)
      OP_BEGIN:  started_d = 1'b1;
      OP_MSG_IN: push = fire;
      OP_START: begin
        if (started_q && link_d && !act_q) begin
          accepted    = 1'b1;
          act_d       = 1'b1;
          req_start_d = now_ms_i;
        end
      end
      OP_POLL: begin
        if (!started_q) begin
          status = ST_FAILED;
        end else if (!act_q) begin
          status = ST_IDLE;
        end else if (!link_d) begin
          act_d  = 1'b0;
          status = ST_FAILED;
        end else if (nonempty) begin
          pop         = fire;
          act_d       = 1'b0;
          req_start_d = '0;
          status      = ST_COMPLETED;
        end else if (resp_timed_out) begin
          act_d       = 1'b0;
          req_start_d = '0;
          status      = ST_TIMEOUT;
        end else begin
          status = ST_PENDING;
        end
      end
      OP_CLOSE: begin
        act_d       = 1'b0;
        req_start_d = '0;
        clr         = fire;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      act_q       <= 1'b0;
      req_start_q <= '0;
    end else if (fire) begin
      started_q   <= started_d;
      act_q       <= act_d;
      req_start_q <= req_start_d;
    end
  end

  // Result register
  lsrt_cmd_t    cmd_q;
  logic         send_q, accepted_q, link_q, resp_sel_q;
  logic [31:0]  send_word_q;
  poll_status_e status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      cmd_q       <= cmd;
      send_q      <= accepted;
      send_word_q <= accepted ? payload_word_i : '0;
      accepted_q  <= accepted;
      status_q    <= status;
      resp_sel_q  <= (status == ST_COMPLETED);
      link_q      <= link_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign radio_begin_o      = cmd_q.radio_begin;
  assign radio_drop_o       = cmd_q.radio_drop;
  assign session_begin_o    = cmd_q.session_begin;
  assign session_drop_o     = cmd_q.session_drop;
  assign send_now_o         = send_q;
  assign send_word_o        = send_word_q;
  assign request_accepted_o = accepted_q;
  assign poll_status_o      = status_q;
  assign response_word_o    = resp_sel_q ? ring_rdata : '0;
  assign link_up_o          = link_q;

  `LSRT_NEVER(a_radio_session_begin, clk_i, rst_ni, fire && cmd.radio_begin && cmd.session_begin)
  `LSRT_ASSERT(a_accept_sets_active, clk_i, rst_ni, (fire && accepted) |=> act_q)
  `LSRT_ASSERT(a_stall_holds_result, clk_i, rst_ni, in_stall_o |=> out_valid_q)

endmodule

// ===== src/lsrt_ring.sv =====
// Message handle ring: pointer logic around a synchronous single-port-read memory.
`include "assert_macros.svh"
module lsrt_ring #(
  parameter int RING_DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        pop_i,
  input  logic        clr_i,
  input  logic [31:0] wdata_i,
  output logic        nonempty_o,
  output logic [31:0] rdata_o
);
  import lsrt_pkg::*;

  localparam int PtrW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CntW = $clog2(RING_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(RING_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(RING_DEPTH);

  logic [31:0]     mem_q [RING_DEPTH];
  logic [31:0]     rdata_q;
  logic [PtrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic            full;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    return (p == LastPtr) ? '0 : p + 1'b1;
  endfunction

  assign full       = (count_q == FullCnt);
  assign nonempty_o = (count_q != '0);
  assign rdata_o    = rdata_q;

  // Advance pointers; a push into a full ring drops the oldest entry
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (clr_i) begin
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
    end else if (push_i) begin
      tail_d = wrap_inc(tail_q);
      if (full) begin
        head_d = wrap_inc(head_q);
      end else begin
        count_d = count_q + 1'b1;
      end
    end else if (pop_i) begin
      head_d  = wrap_inc(head_q);
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Write the tail entry on push
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[tail_q] <= wdata_i;
    end
  end

  // Read the head entry on pop; data holds until the next pop
  always_ff @(posedge clk_i) begin
    if (pop_i) begin
      rdata_q <= mem_q[head_q];
    end
  end

  `LSRT_NEVER(a_count_bound, clk_i, rst_ni, count_q > FullCnt)
  `LSRT_NEVER(a_pop_empty, clk_i, rst_ni, pop_i && !clr_i && count_q == '0)
  `LSRT_ASSERT(a_push_fills, clk_i, rst_ni, (push_i && !clr_i) |=> (count_q != '0))

endmodule

// ===== src/lsrt_supervisor.sv =====
// Reconnect rule: attempt stamps, pending flags and session state.
module lsrt_supervisor (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lsrt_pkg::lsrt_sup_ctl_t ctl_i,
  input  lsrt_pkg::lsrt_timing_t  timing_i,
  input  logic [31:0]           now_ms_i,
  input  logic                  radio_up_i,
  output lsrt_pkg::lsrt_cmd_t     cmd_o,
  output logic                  conn_d_o
);
  import lsrt_pkg::*;

  logic        conn_q, conn_d;
  logic        rpend_q, rpend_d, spend_q, spend_d;
  logic [31:0] last_r_q, last_r_d, start_r_q, start_r_d;
  logic [31:0] last_s_q, last_s_d, start_s_q, start_s_d;
  logic        rpend, spend;
  logic [31:0] last_r, start_r, last_s, start_s;
  logic        r_wait, r_retry, s_wait, s_retry;
  lsrt_cmd_t   cmd;

  // Begin wipes stamps and pending flags before the rule looks at them
  assign rpend   = ctl_i.clear ? 1'b0 : rpend_q;
  assign spend   = ctl_i.clear ? 1'b0 : spend_q;
  assign last_r  = ctl_i.clear ? '0 : last_r_q;
  assign start_r = ctl_i.clear ? '0 : start_r_q;
  assign last_s  = ctl_i.clear ? '0 : last_s_q;
  assign start_s = ctl_i.clear ? '0 : start_s_q;

  // Elapsed-time compares, modulo 2^32
  assign r_wait  = (now_ms_i - start_r) < timing_i.radio_timeout;
  assign r_retry = (now_ms_i - last_r) >= timing_i.radio_retry;
  assign s_wait  = (now_ms_i - start_s) < timing_i.sess_timeout;
  assign s_retry = (now_ms_i - last_s) >= timing_i.sess_retry;

  always_comb begin
    cmd       = '0;
    conn_d    = conn_q;
    rpend_d   = rpend;
    spend_d   = spend;
    last_r_d  = last_r;
    start_r_d = start_r;
    last_s_d  = last_s;
    start_s_d = start_s;
    if (ctl_i.sess_set) begin
      conn_d  = 1'b1;
      spend_d = 1'b0;
    end else if (ctl_i.sess_clr) begin
      conn_d  = 1'b0;
      spend_d = 1'b0;
    end else if (ctl_i.run) begin
      if (!radio_up_i) begin
        // Radio down: drop the session, then time out or retry the radio
        conn_d           = 1'b0;
        spend_d          = 1'b0;
        cmd.session_drop = 1'b1;
        if (!(rpend && r_wait)) begin
          if (rpend) begin
            cmd.radio_drop = 1'b1;
            rpend_d        = 1'b0;
          end
          if (r_retry) begin
            cmd.radio_begin = 1'b1;
            last_r_d        = now_ms_i;
            start_r_d       = now_ms_i;
            rpend_d         = 1'b1;
          end
        end
      end else begin
        // Radio up: time out or retry the session unless connected
        rpend_d = 1'b0;
        if (!conn_q && !(spend && s_wait)) begin
          if (spend) begin
            cmd.session_drop = 1'b1;
            spend_d          = 1'b0;
          end
          if (s_retry) begin
            cmd.session_drop  = 1'b1;
            cmd.session_begin = 1'b1;
            last_s_d          = now_ms_i;
            start_s_d         = now_ms_i;
            spend_d           = 1'b1;
          end
        end
      end
    end
  end

  assign cmd_o    = cmd;
  assign conn_d_o = conn_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conn_q    <= 1'b0;
      rpend_q   <= 1'b0;
      spend_q   <= 1'b0;
      last_r_q  <= '0;
      start_r_q <= '0;
      last_s_q  <= '0;
      start_s_q <= '0;
    end else begin
      conn_q    <= conn_d;
      rpend_q   <= rpend_d;
      spend_q   <= spend_d;
      last_r_q  <= last_r_d;
      start_r_q <= start_r_d;
      last_s_q  <= last_s_d;
      start_s_q <= start_s_d;
    end
  end

endmodule

// ===== test/link_supervisor_checker.sv =====
// Checker for the link supervisor: predicts every result beat and compares the output channel.
module link_supervisor_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port, observed
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  // input channel, observed
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  opcode_i,
  input  logic [31:0] now_ms_i,
  input  logic        radio_up_i,
  input  logic [31:0] message_word_i,
  input  logic [31:0] payload_word_i,
  // output channel, observed
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        radio_begin_i,
  input  logic        radio_drop_i,
  input  logic        session_begin_i,
  input  logic        session_drop_i,
  input  logic        send_now_i,
  input  logic [31:0] send_word_i,
  input  logic        request_accepted_i,
  input  logic [2:0]  poll_status_i,
  input  logic [31:0] response_word_i,
  input  logic        link_up_i,
  // status toward the testbench top
  output int          mismatch_count_o,
  output int          results_seen_o,
  output int          results_owed_o
);
  import lsrt_pkg::*;

  localparam int MsgRingDepth = 8;

  typedef struct packed {
    logic         radio_begin;
    logic         radio_drop;
    logic         session_begin;
    logic         session_drop;
    logic         send_now;
    logic [31:0]  send_word;
    logic         request_accepted;
    poll_status_e poll_status;
    logic [31:0]  response_word;
    logic         link_up;
  } link_result_t;

  // results predicted but not yet seen on the output channel
  link_result_t predicted_q[$];
  link_result_t head_r;
  link_result_t next_r;
  int           mismatches = 0;

  // timing registers as the block should hold them
  logic [31:0] resp_timeout;
  logic [31:0] radio_timeout;
  logic [31:0] radio_retry;
  logic [31:0] sess_timeout;
  logic [31:0] sess_retry;

  // link and request state
  logic        started;
  logic        sess_conn;
  logic        radio_pend;
  logic        sess_pend;
  logic        req_active;
  logic [31:0] req_start;
  logic [31:0] last_radio;
  logic [31:0] radio_start;
  logic [31:0] last_sess;
  logic [31:0] sess_start;
  lsrt_cmd_t   cmd;

  // message ring
  int          ring_rd;
  int          ring_wr;
  int          ring_fill;
  logic [31:0] ring_mem [MsgRingDepth];

  assign mismatch_count_o = mismatches;

  function automatic logic [31:0] ms_since(input logic [31:0] now, input logic [31:0] stamp);
    return now - stamp;
  endfunction

  task automatic reset_model();
    resp_timeout  = RESP_TIMEOUT_RST;
    radio_timeout = RADIO_TIMEOUT_RST;
    radio_retry   = RADIO_RETRY_RST;
    sess_timeout  = SESS_TIMEOUT_RST;
    sess_retry    = SESS_RETRY_RST;
    started       = 1'b0;
    sess_conn     = 1'b0;
    radio_pend    = 1'b0;
    sess_pend     = 1'b0;
    req_active    = 1'b0;
    req_start     = '0;
    last_radio    = '0;
    radio_start   = '0;
    last_sess     = '0;
    sess_start    = '0;
    ring_rd       = 0;
    ring_wr       = 0;
    ring_fill     = 0;
    predicted_q.delete();
  endtask

  task automatic write_timing(input logic [2:0] idx, input logic [31:0] value);
    case (idx)
      CFG_RESP_TIMEOUT:  resp_timeout  = value;
      CFG_RADIO_TIMEOUT: radio_timeout = value;
      CFG_RADIO_RETRY:   radio_retry   = value;
      CFG_SESS_TIMEOUT:  sess_timeout  = value;
      CFG_SESS_RETRY:    sess_retry    = value;
      default: ;
    endcase
  endtask

  // Time out pending connects and start new attempts when the retry spacing allows.
  task automatic run_reconnect(input logic [31:0] now, input logic radio);
    if (!radio) begin
      sess_conn        = 1'b0;
      sess_pend        = 1'b0;
      cmd.session_drop = 1'b1;
      if (radio_pend && ms_since(now, radio_start) >= radio_timeout) begin
        cmd.radio_drop = 1'b1;
        radio_pend     = 1'b0;
      end
      if (!radio_pend && ms_since(now, last_radio) >= radio_retry) begin
        cmd.radio_begin = 1'b1;
        last_radio      = now;
        radio_start     = now;
        radio_pend      = 1'b1;
      end
    end else begin
      radio_pend = 1'b0;
      if (!sess_conn) begin
        if (sess_pend && ms_since(now, sess_start) >= sess_timeout) begin
          cmd.session_drop = 1'b1;
          sess_pend        = 1'b0;
        end
        if (!sess_pend && ms_since(now, last_sess) >= sess_retry) begin
          cmd.session_drop  = 1'b1;
          cmd.session_begin = 1'b1;
          last_sess         = now;
          sess_start        = now;
          sess_pend         = 1'b1;
        end
      end
    end
  endtask

  // Work out the result of one input beat and advance the state.
  task automatic step_supervisor(input logic [2:0] op, input logic [31:0] now, input logic radio,
                                 input logic [31:0] msg, input logic [31:0] payload,
                                 output link_result_t res);
    res = '0;
    cmd = '0;
    case (op)
      OP_BEGIN: begin
        last_radio  = '0;
        radio_start = '0;
        last_sess   = '0;
        radio_pend  = 1'b0;
        sess_start  = '0;
        sess_pend   = 1'b0;
        run_reconnect(now, radio);
        started     = 1'b1;
      end
      OP_SERVICE: begin
        if (started) run_reconnect(now, radio);
      end
      OP_SESS_UP: begin
        sess_conn = 1'b1;
        sess_pend = 1'b0;
      end
      OP_SESS_DOWN: begin
        sess_conn = 1'b0;
        sess_pend = 1'b0;
      end
      OP_MSG_IN: begin
        // drop the oldest handle when the ring is full
        if (ring_fill >= MsgRingDepth) begin
          ring_rd   = (ring_rd + 1) % MsgRingDepth;
          ring_fill = ring_fill - 1;
        end
        ring_mem[ring_wr] = msg;
        ring_wr   = (ring_wr + 1) % MsgRingDepth;
        ring_fill = ring_fill + 1;
      end
      OP_START: begin
        if (started) begin
          run_reconnect(now, radio);
          if (radio && sess_conn && !req_active) begin
            res.send_now         = 1'b1;
            res.send_word        = payload;
            res.request_accepted = 1'b1;
            req_active           = 1'b1;
            req_start            = now;
          end
        end
      end
      OP_POLL: begin
        if (!started) begin
          res.poll_status = ST_FAILED;
        end else begin
          run_reconnect(now, radio);
          if (!req_active) begin
            res.poll_status = ST_IDLE;
          end else if (!(radio && sess_conn)) begin
            req_active      = 1'b0;
            res.poll_status = ST_FAILED;
          end else if (ring_fill != 0) begin
            res.response_word = ring_mem[ring_rd];
            ring_rd           = (ring_rd + 1) % MsgRingDepth;
            ring_fill         = ring_fill - 1;
            req_active        = 1'b0;
            req_start         = '0;
            res.poll_status   = ST_COMPLETED;
          end else if (ms_since(now, req_start) >= resp_timeout) begin
            req_active      = 1'b0;
            req_start       = '0;
            res.poll_status = ST_TIMEOUT;
          end else begin
            res.poll_status = ST_PENDING;
          end
        end
      end
      default: begin
        // close: end the request and empty the ring, keep the link state
        req_active = 1'b0;
        req_start  = '0;
        ring_rd    = 0;
        ring_wr    = 0;
        ring_fill  = 0;
      end
    endcase
    res.radio_begin   = cmd.radio_begin;
    res.radio_drop    = cmd.radio_drop;
    res.session_begin = cmd.session_begin;
    res.session_drop  = cmd.session_drop;
    res.link_up       = radio && sess_conn;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  task automatic compare_beat(input link_result_t exp_r);
    check_field("radio_begin", exp_r.radio_begin, radio_begin_i);
    check_field("radio_drop", exp_r.radio_drop, radio_drop_i);
    check_field("session_begin", exp_r.session_begin, session_begin_i);
    check_field("session_drop", exp_r.session_drop, session_drop_i);
    check_field("send_now", exp_r.send_now, send_now_i);
    check_field("send_word", exp_r.send_word, send_word_i);
    check_field("request_accepted", exp_r.request_accepted, request_accepted_i);
    check_field("poll_status", exp_r.poll_status, poll_status_i);
    check_field("response_word", exp_r.response_word, response_word_i);
    check_field("link_up", exp_r.link_up, link_up_i);
  endtask

  // Compare leaving beats, track register writes, predict entering beats.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_model();
      results_seen_o <= 0;
      results_owed_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (predicted_q.size() == 0) begin
          $display("%0t: result beat with no prediction waiting", $time);
          mismatches++;
        end else begin
          head_r = predicted_q.pop_front();
          compare_beat(head_r);
        end
        results_seen_o <= results_seen_o + 1;
      end
      if (cfg_we_i) write_timing(cfg_idx_i, cfg_wdata_i);
      if (in_valid_i && !in_stall_i) begin
        step_supervisor(opcode_i, now_ms_i, radio_up_i, message_word_i, payload_word_i, next_r);
        predicted_q.push_back(next_r);
      end
      results_owed_o <= predicted_q.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the link supervisor: clock, reset, stimulus, receiver stalls and verdict.
module tb_top;
  import lsrt_pkg::*;

  localparam int HalfPeriod  = 5;
  localparam int MaxWait     = 17;
  localparam int LongHold    = 400;
  localparam int RandomItems = 1050;
  localparam int NumPhases   = 9;
  localparam int TimeLimit   = 4_000_000;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic [2:0]  cfg_idx_i      = CFG_RESP_TIMEOUT;
  logic [31:0] cfg_wdata_i    = '0;
  logic        in_valid_i     = 1'b0;
  logic [2:0]  opcode_i       = OP_SERVICE;
  logic [31:0] now_ms_i       = '0;
  logic        radio_up_i     = 1'b0;
  logic [31:0] message_word_i = '0;
  logic [31:0] payload_word_i = '0;
  logic        out_stall_i    = 1'b0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic        radio_begin_o;
  logic        radio_drop_o;
  logic        session_begin_o;
  logic        session_drop_o;
  logic        send_now_o;
  logic [31:0] send_word_o;
  logic        request_accepted_o;
  logic [2:0]  poll_status_o;
  logic [31:0] response_word_o;
  logic        link_up_o;

  int mismatch_count;
  int results_seen;
  int results_owed;

  // stimulus state
  logic [31:0] wall_ms          = '0;
  logic [31:0] tim_scale        = 32'd5000;
  logic        radio_level      = 1'b0;
  int          beats_sent       = 0;
  bit          no_idle          = 1'b0;
  bit          rx_long_hold_req = 1'b0;

  link_supervisor_with_request_timeout i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .opcode_i           (opcode_i),
    .now_ms_i           (now_ms_i),
    .radio_up_i         (radio_up_i),
    .message_word_i     (message_word_i),
    .payload_word_i     (payload_word_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .radio_begin_o      (radio_begin_o),
    .radio_drop_o       (radio_drop_o),
    .session_begin_o    (session_begin_o),
    .session_drop_o     (session_drop_o),
    .send_now_o         (send_now_o),
    .send_word_o        (send_word_o),
    .request_accepted_o (request_accepted_o),
    .poll_status_o      (poll_status_o),
    .response_word_o    (response_word_o),
    .link_up_o          (link_up_o)
  );

  link_supervisor_checker i_link_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_i         (in_stall_o),
    .opcode_i           (opcode_i),
    .now_ms_i           (now_ms_i),
    .radio_up_i         (radio_up_i),
    .message_word_i     (message_word_i),
    .payload_word_i     (payload_word_i),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .radio_begin_i      (radio_begin_o),
    .radio_drop_i       (radio_drop_o),
    .session_begin_i    (session_begin_o),
    .session_drop_i     (session_drop_o),
    .send_now_i         (send_now_o),
    .send_word_i        (send_word_o),
    .request_accepted_i (request_accepted_o),
    .poll_status_i      (poll_status_o),
    .response_word_i    (response_word_o),
    .link_up_i          (link_up_o),
    .mismatch_count_o   (mismatch_count),
    .results_seen_o     (results_seen),
    .results_owed_o     (results_owed)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Give up after a generous fixed time.
  initial begin
    #(TimeLimit);
    $display("Simulation FAILED");
    $finish;
  end

  // Stall the output channel: a random wait after every beat, one long hold-off on request.
  initial begin : rx_side
    int rx_wait;
    rx_wait = 0;
    forever begin
      @(posedge clk_i);
      if (rx_long_hold_req) begin
        rx_long_hold_req = 1'b0;
        rx_wait = LongHold;
      end else if (out_valid_o && !out_stall_i) begin
        rx_wait = no_idle ? 0 : $urandom_range(0, MaxWait);
      end
      if (rx_wait > 0) begin
        out_stall_i <= 1'b1;
        rx_wait--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offer one beat after a random gap and hold it until accepted.
  task automatic send_beat(input logic [2:0] op, input logic [31:0] now, input logic radio,
                           input logic [31:0] msg, input logic [31:0] payload);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MaxWait);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    now_ms_i       <= now;
    radio_up_i     <= radio;
    message_word_i <= msg;
    payload_word_i <= payload;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
  endtask

  // Step the millisecond clock: mostly around the timing scale, sometimes wrapping or stepping back.
  task automatic advance_time();
    logic [31:0] delta;
    case ($urandom_range(0, 19))
      0, 1:    delta = '0;
      2:       delta = 32'hFFFF_FFFF;
      3:       delta = $urandom;
      4, 5:    delta = tim_scale;
      6:       delta = tim_scale - 1;
      default: delta = $urandom_range(0, tim_scale / 2);
    endcase
    wall_ms = wall_ms + delta;
  endtask

  task automatic tick_beat(input logic [2:0] op, input logic radio);
    advance_time();
    send_beat(op, wall_ms, radio, $urandom, $urandom);
  endtask

  // Drop valid and wait until every predicted result has left the block.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (results_seen != beats_sent) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic load_timing(input logic [31:0] resp, input logic [31:0] radio_to,
                             input logic [31:0] radio_rt, input logic [31:0] sess_to,
                             input logic [31:0] sess_rt);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_RESP_TIMEOUT;
    cfg_wdata_i <= resp;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_RADIO_TIMEOUT;
    cfg_wdata_i <= radio_to;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_RADIO_RETRY;
    cfg_wdata_i <= radio_rt;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_SESS_TIMEOUT;
    cfg_wdata_i <= sess_to;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_SESS_RETRY;
    cfg_wdata_i <= sess_rt;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Pick the timing of one phase: all zero, all max, then small and full-range values.
  task automatic set_timing(input int phase);
    case (phase)
      1: begin
        load_timing('0, '0, '0, '0, '0);
        tim_scale = 32'd8;
      end
      2: begin
        load_timing('1, '1, '1, '1, '1);
        tim_scale = 32'd200;
      end
      NumPhases - 1: begin
        load_timing($urandom, $urandom, $urandom, $urandom, $urandom);
        tim_scale = 32'd40;
      end
      default: begin
        load_timing($urandom_range(0, 50), $urandom_range(0, 50), $urandom_range(0, 50),
                    $urandom_range(0, 50), $urandom_range(0, 50));
        tim_scale = 32'd40;
      end
    endcase
  endtask

  // Walk through each opcode before begin, both connect levels, the request outcomes and wrap.
  task automatic run_directed();
    send_beat(OP_POLL,      32'd0,     1'b0, '0, '0);
    send_beat(OP_SERVICE,   32'd10,    1'b1, '0, '0);
    send_beat(OP_START,     32'd20,    1'b1, '0, '1);
    send_beat(OP_SESS_UP,   32'd30,    1'b1, '0, '0);
    send_beat(OP_SESS_DOWN, 32'd40,    1'b1, '0, '0);
    send_beat(OP_MSG_IN,    32'd50,    1'b0, '0, '0);
    send_beat(OP_CLOSE,     32'd60,    1'b0, '0, '0);
    send_beat(OP_BEGIN,     32'd100,   1'b0, '0, '0);
    send_beat(OP_SERVICE,   32'd3100,  1'b0, '0, '0);
    send_beat(OP_SERVICE,   32'd3200,  1'b0, '0, '0);
    send_beat(OP_SERVICE,   32'd18100, 1'b0, '0, '0);
    send_beat(OP_SERVICE,   32'd18200, 1'b1, '0, '0);
    send_beat(OP_SERVICE,   32'd19000, 1'b1, '0, '0);
    send_beat(OP_SERVICE,   32'd23200, 1'b1, '0, '0);
    send_beat(OP_SESS_UP,   32'd23300, 1'b1, '0, '0);
    send_beat(OP_START,     32'd23400, 1'b1, '0, '1);
    send_beat(OP_START,     32'd23500, 1'b1, '0, '0);
    send_beat(OP_POLL,      32'd23600, 1'b1, '0, '0);
    send_beat(OP_MSG_IN,    32'd23700, 1'b1, '1, '0);
    send_beat(OP_POLL,      32'd23800, 1'b1, '0, '0);
    // request that times out across the wrap of the millisecond clock
    send_beat(OP_START,     32'hFFFF_F000, 1'b1, '0, '0);
    send_beat(OP_POLL,      32'h0000_0388, 1'b1, '0, '0);
    // request that fails when the radio goes down
    send_beat(OP_START,     32'h0000_0400, 1'b1, '0, 32'h5A5A_5A5A);
    send_beat(OP_POLL,      32'h0000_0500, 1'b0, '0, '0);
    send_beat(OP_BEGIN,     32'hFFFF_FFFF, 1'b1, '0, '0);
    wall_ms = 32'hFFFF_FFFF;
  endtask

  // One connect-and-request sequence with random timing and occasional faults.
  task automatic session_script();
    int n;
    if ($urandom_range(0, 3) == 0) tick_beat(OP_BEGIN, $urandom_range(0, 1));
    n = $urandom_range(0, 3);
    repeat (n) tick_beat(OP_SERVICE, 1'b0);
    n = $urandom_range(1, 3);
    repeat (n) tick_beat(OP_SERVICE, 1'b1);
    // bring the session up, sometimes report an error instead
    tick_beat(($urandom_range(0, 4) == 0) ? OP_SESS_DOWN : OP_SESS_UP, 1'b1);
    tick_beat(OP_START, 1'b1);
    n = $urandom_range(0, 4);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0:       tick_beat(OP_MSG_IN, 1'b1);
        1:       tick_beat(OP_POLL, 1'b1);
        2:       tick_beat(OP_SERVICE, 1'b1);
        default: tick_beat(OP_START, 1'b1);
      endcase
    end
    // lose the radio now and then while the request is out
    radio_level = ($urandom_range(0, 5) != 0);
    n = $urandom_range(1, 3);
    repeat (n) tick_beat(OP_POLL, radio_level);
    // overflow the ring now and then
    if ($urandom_range(0, 5) == 0) begin
      n = $urandom_range(7, 11);
      repeat (n) tick_beat(OP_MSG_IN, radio_level);
    end
    if ($urandom_range(0, 4) == 0) tick_beat(OP_CLOSE, radio_level);
  endtask

  // A short run of arbitrary beats.
  task automatic noise_burst();
    int          n;
    logic        radio;
    logic [2:0]  op_bits;
    n = $urandom_range(1, 6);
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) radio_level = ~radio_level;
      radio   = ($urandom_range(0, 9) == 0) ? ~radio_level : radio_level;
      op_bits = $urandom_range(0, 7);
      tick_beat(op_bits, radio);
    end
  endtask

  initial begin : stimulus
    int phase;
    int base_beats;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    drain_results();
    base_beats = beats_sent;
    for (phase = 0; phase < NumPhases; phase++) begin
      if (phase > 0) begin
        drain_results();
        set_timing(phase);
      end
      // hold off the receiver while beats keep coming
      if (phase == 1) rx_long_hold_req = 1'b1;
      while (beats_sent < base_beats + (phase + 1) * RandomItems / NumPhases) begin
        no_idle = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 9) < 7) begin
          session_script();
        end else begin
          noise_burst();
        end
        if ($urandom_range(0, 24) == 0) drain_results();
      end
    end
    drain_results();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
